// ===== sv/sfe_pkg.sv =====
package sfe_pkg;

   // Ring of past output frames
   localparam int RING_DEPTH = 32768;
   localparam int ADDR_W     = $clog2(RING_DEPTH);
   localparam int SEEN_W     = ADDR_W + 1;

   // Sample and gain formats
   localparam int SAMPLE_W = 16;
   localparam int FRAME_W  = 2 * SAMPLE_W;
   localparam int GAIN_W   = 16;
   localparam int Q_BITS   = 15;
   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << Q_BITS);

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WET      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK = 2'd2;

   // One stereo frame as stored in the ring: left low, right high
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] right;
      logic signed [SAMPLE_W-1:0] left;
   } frame_type;

endpackage

// ===== sv/sfe_ram.sv =====
module sfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port; a read colliding with a write sees old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sfe_channel.sv =====
module sfe_channel import sfe_pkg::*; (
   input  logic signed [SAMPLE_W-1:0] sample_in,
   input  logic signed [SAMPLE_W-1:0] delayed,
   input  logic        [GAIN_W-1:0]   wet_gain,
   input  logic        [GAIN_W-1:0]   feedback_gain,
   output logic signed [SAMPLE_W-1:0] sample_out
);

   localparam int ACC_W = 2 * (GAIN_W + 1);
   localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((1 << Q_BITS) - 1);

   logic signed [GAIN_W:0]      x_s, y_s, wet_s, dry_s, fb_s;
   logic signed [ACC_W-1:0]     dry_prod, wet_prod, fb_prod;
   logic signed [ACC_W-1:0]     mix_sum, mix_q, fb_sum, fb_q;
   logic signed [SAMPLE_W-1:0]  mix_sat;

   // Clamp to the 16-bit sample range
   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi, lo;
      hi = ACC_W'(32767);
      lo = -ACC_W'(32768);
      if (v > hi) begin
         sat16 = 16'sh7fff;
      end else if (v < lo) begin
         sat16 = 16'sh8000;
      end else begin
         sat16 = v[SAMPLE_W-1:0];
      end
   endfunction

   // Operands widened to 17-bit signed; gains are already clamped to one
   assign x_s   = (GAIN_W+1)'(sample_in);
   assign y_s   = (GAIN_W+1)'(delayed);
   assign wet_s = signed'({1'b0, wet_gain});
   assign dry_s = signed'({1'b0, GAIN_ONE} - {1'b0, wet_gain});
   assign fb_s  = signed'({1'b0, feedback_gain});

   // Three 17x17 multipliers side by side
   assign dry_prod = ACC_W'(x_s) * ACC_W'(dry_s);
   assign wet_prod = ACC_W'(y_s) * ACC_W'(wet_s);
   assign fb_prod  = ACC_W'(y_s) * ACC_W'(fb_s);

   // Dry/wet mix, Q15 truncated toward zero, then saturated
   assign mix_sum = dry_prod + wet_prod;
   assign mix_q   = mix_sum[ACC_W-1] ? ((mix_sum + TRUNC_BIAS) >>> Q_BITS)
                                     : (mix_sum >>> Q_BITS);
   assign mix_sat = sat16(mix_q);

   // Feedback term added at full precision, truncated and saturated again
   assign fb_sum = (ACC_W'(mix_sat) <<< Q_BITS) + fb_prod;
   assign fb_q   = fb_sum[ACC_W-1] ? ((fb_sum + TRUNC_BIAS) >>> Q_BITS)
                                   : (fb_sum >>> Q_BITS);
   assign sample_out = sat16(fb_q);

endmodule

// ===== sv/stereo_feedback_echo.sv =====
// Stereo feedback echo. Takes one signed 16-bit stereo frame per beat and
// returns one processed frame per beat, one frame per clock sustained unless
// rsp_ready holds the output; each frame passes the compute stage and then the
// result register. Each output frame is stored in a 32768-frame ring memory with
// one write and one registered read port; the echo tap is read when a frame is
// accepted and used in the compute stage, with the frame being written forwarded
// when the tap hits it (delay of one). Until more frames than the delay have
// passed, input goes straight through. The ring is not cleared after reset; the
// block never uses an entry before it has been written. Gains are Q1.15 (32768 =
// 1.0, larger values act as 1.0); a delay of zero acts as one. Write
// configuration only while no beat is in flight.
module stereo_feedback_echo import sfe_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   // configuration
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [GAIN_W-1:0]          csr_wdata,
   // input frames
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_left_in,
   input  logic signed [SAMPLE_W-1:0] req_right_in,
   input  logic                       req_block_end,
   // result frames
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_left_out,
   output logic signed [SAMPLE_W-1:0] rsp_right_out,
   output logic                       rsp_block_end_out
);

   // Configuration registers
   logic [ADDR_W-1:0] delay_ff, delay_in;
   logic [GAIN_W-1:0] wet_ff, wet_in;
   logic [GAIN_W-1:0] fb_ff, fb_in;

   // Ring bookkeeping
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;

   // Compute stage
   logic              s1_valid_ff, s1_valid_in;
   frame_type         s1_frame_ff;
   logic              s1_end_ff;
   logic              s1_echo_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              s1_byp_ff;
   frame_type         byp_data_ff;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   frame_type         rsp_frame_ff;
   logic              rsp_end_ff;

   logic              req_fire, s1_fire, echo_now, byp_now;
   logic [ADDR_W-1:0] delay_eff, rd_addr;
   frame_type         ram_rdata, delayed, echo_frame, result;

   // Configuration writes; gains above one clamp to one
   always_comb begin
      delay_in = delay_ff;
      wet_in   = wet_ff;
      fb_in    = fb_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DELAY:    delay_in = csr_wdata[ADDR_W-1:0];
            CSR_WET:      wet_in   = (csr_wdata > GAIN_ONE) ? GAIN_ONE : csr_wdata;
            CSR_FEEDBACK: fb_in    = (csr_wdata > GAIN_ONE) ? GAIN_ONE : csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   // Tap address and echo enable, taken at accept
   assign delay_eff = (delay_ff == '0) ? ADDR_W'(1) : delay_ff;
   assign echo_now  = seen_ff > {1'b0, delay_eff};
   assign rd_addr   = wp_ff - delay_eff;
   assign byp_now   = s1_fire && (rd_addr == s1_addr_ff);

   always_comb begin
      wp_in   = wp_ff;
      seen_in = seen_ff;
      if (req_fire) begin
         wp_in = wp_ff + ADDR_W'(1);
         if (seen_ff <= {1'b0, delay_eff}) begin
            seen_in = seen_ff + SEEN_W'(1);
         end
      end
   end

   assign s1_valid_in = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= ADDR_W'(1);
         wet_ff       <= '0;
         fb_ff        <= '0;
         wp_ff        <= '0;
         seen_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         delay_ff     <= delay_in;
         wet_ff       <= wet_in;
         fb_ff        <= fb_in;
         wp_ff        <= wp_in;
         seen_ff      <= seen_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_frame_ff.left  <= req_left_in;
         s1_frame_ff.right <= req_right_in;
         s1_end_ff         <= req_block_end;
         s1_echo_ff        <= echo_now;
         s1_addr_ff        <= wp_ff;
         s1_byp_ff         <= byp_now;
         byp_data_ff       <= result;
      end
      if (s1_fire) begin
         rsp_frame_ff <= result;
         rsp_end_ff   <= s1_end_ff;
      end
   end

   // Ring of past output frames
   sfe_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_addr_ff),
      .wr_data (result),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // Forward the frame written in the same cycle as the tap read
   assign delayed = s1_byp_ff ? byp_data_ff : ram_rdata;

   sfe_channel u_left (
      .sample_in     (s1_frame_ff.left),
      .delayed       (delayed.left),
      .wet_gain      (wet_ff),
      .feedback_gain (fb_ff),
      .sample_out    (echo_frame.left)
   );

   sfe_channel u_right (
      .sample_in     (s1_frame_ff.right),
      .delayed       (delayed.right),
      .wet_gain      (wet_ff),
      .feedback_gain (fb_ff),
      .sample_out    (echo_frame.right)
   );

   assign result = s1_echo_ff ? echo_frame : s1_frame_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_out      = rsp_frame_ff.left;
   assign rsp_right_out     = rsp_frame_ff.right;
   assign rsp_block_end_out = rsp_end_ff;

endmodule
